/* rtl/qvp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qvp_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INV     = 3'd1,
    ST_BIG     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_DECMISS = 3'd4
  } qvp_status_e;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_START = 7'b0000001,
    PH_ZERO  = 7'b0000010,
    PH_ONE   = 7'b0000100,
    PH_ZPT   = 7'b0001000,
    PH_OPT   = 7'b0010000,
    PH_OPT0  = 7'b0100000,
    PH_FRAC  = 7'b1000000
  } qvp_phase_e;

  localparam logic [9:0] Q_ONE      = 10'd1000;
  localparam logic [6:0] W_HUNDREDS = 7'd100;
  localparam logic [6:0] W_TENS     = 7'd10;
  localparam logic [6:0] W_UNITS    = 7'd1;
  localparam logic [6:0] W_NONE     = 7'd0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;

  typedef struct packed {
    logic       end_mark;
    logic [7:0] char_code;
  } qvp_item_t;

  typedef struct packed {
    logic [9:0]  q_thousandths;
    qvp_status_e status;
  } qvp_result_t;

endpackage

`default_nettype wire

/* rtl/sip_qvalue_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o  | char_code_i[7:0], end_mark_i
// out     | output    | out_valid_o / out_stall_i| q_thousandths_o[9:0], status_o[2:0]
//
// One character per cycle while no end mark is held back. A transaction is registered in the
// input register; when it moves on, the parser state and, for an end mark, the result
// register update, so a result is valid in the cycle after its end mark leaves the input
// register and can leave as soon as the receiver does not stall.
// Reset clears the parser to the start phase and empties both registers.
// Character transactions keep flowing while a result waits; only an end mark
// holds in the input register until the result register is free.

module sip_qvalue_parser
  import qvp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       end_mark_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [9:0]      q_thousandths_o,
  output logic [2:0]      status_o
);

  qvp_item_t   in_item;
  qvp_item_t   s1_item;
  logic        s1_valid;
  logic        s1_adv;
  logic        out_free;
  qvp_result_t result;

  logic        out_valid_q, out_valid_d;
  qvp_result_t out_q;

  assign in_item.end_mark  = end_mark_i;
  assign in_item.char_code = char_code_i;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_adv   = s1_valid && (!s1_item.end_mark || out_free);

  qvp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item),
    .in_stall_o (in_stall_o),
    .adv_i      (s1_adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  qvp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .item_i   (s1_item),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_item.end_mark) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_item.end_mark) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign q_thousandths_o = out_q.q_thousandths;
  assign status_o        = out_q.status;

  // An end mark is held back only by a result that is still waiting.
  a_end_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1_item.end_mark && !s1_adv) |-> (out_valid_o && out_stall_i))
    else $error("end mark held without a blocked result");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_item.end_mark) |=> out_valid_o)
    else $error("end mark did not produce a result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (q_thousandths_o == 10'd0))
    else $error("nonzero value reported with an error status");

endmodule

`default_nettype wire

/* rtl/qvp_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module qvp_in_stage
  import qvp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire qvp_item_t in_item_i,
  output logic           in_stall_o,
  input  wire logic      adv_i,
  output logic           valid_o,
  output qvp_item_t      item_o
);

  logic      valid_q, valid_d;
  qvp_item_t item_q;
  logic      accept;

  // The stage only holds when its transaction cannot move on.
  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/qvp_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module qvp_parser
  import qvp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire qvp_item_t item_i,
  output qvp_result_t    result_o
);

  qvp_phase_e  phase_q, phase_d;
  logic [9:0]  value_q, value_d;
  logic [6:0]  weight_q, weight_d;
  qvp_status_e err_q, err_d;

  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  digit;
  logic [9:0]  prod;
  logic [6:0]  weight_next;
  logic [9:0]  frac_sum;

  assign c        = item_i.char_code;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = c[3:0];
  assign prod     = 10'({6'd0, digit} * {3'd0, weight_q});
  assign frac_sum = 10'(value_q + prod);

  // Weight of the following decimal; it drops to zero after the third one.
  always_comb begin
    case (weight_q)
      W_HUNDREDS: weight_next = W_TENS;
      W_TENS:     weight_next = W_UNITS;
      default:    weight_next = W_NONE;
    endcase
  end

  always_comb begin
    result_o.q_thousandths = 10'd0;
    if (err_q != ST_OK) begin
      result_o.status = err_q;
    end else if (phase_q == PH_START) begin
      result_o.status = ST_EMPTY;
    end else if (phase_q == PH_ZPT || phase_q == PH_OPT) begin
      result_o.status = ST_DECMISS;
    end else begin
      result_o.status        = ST_OK;
      result_o.q_thousandths = value_q;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    value_d  = value_q;
    weight_d = weight_q;
    err_d    = err_q;
    if (adv_i) begin
      if (item_i.end_mark) begin
        phase_d  = PH_START;
        value_d  = 10'd0;
        weight_d = W_HUNDREDS;
        err_d    = ST_OK;
      end else if (err_q == ST_OK) begin
        case (phase_q)
          PH_START: begin
            if (c == CH_SPACE || c == CH_TAB) begin
              phase_d = PH_START;
            end else if (c == CH_ZERO) begin
              value_d = 10'd0;
              phase_d = PH_ZERO;
            end else if (c == CH_ONE) begin
              value_d = Q_ONE;
              phase_d = PH_ONE;
            end else if (c == CH_POINT) begin
              phase_d = PH_ZPT;
            end else begin
              err_d = ST_INV;
            end
          end
          PH_ZERO: begin
            if (c == CH_ZERO) begin
              phase_d = PH_ZERO;
            end else if (c == CH_POINT) begin
              phase_d = PH_ZPT;
            end else if (c == CH_ONE) begin
              value_d = Q_ONE;
              phase_d = PH_ONE;
            end else begin
              err_d = is_digit ? ST_BIG : ST_INV;
            end
          end
          PH_ONE: begin
            if (c == CH_POINT) begin
              phase_d = PH_OPT;
            end else begin
              err_d = is_digit ? ST_BIG : ST_INV;
            end
          end
          PH_ZPT: begin
            if (is_digit) begin
              value_d  = prod;
              weight_d = weight_next;
              phase_d  = PH_FRAC;
            end else begin
              err_d = ST_INV;
            end
          end
          PH_OPT, PH_OPT0: begin
            if (c == CH_ZERO) begin
              phase_d = PH_OPT0;
            end else begin
              err_d = is_digit ? ST_BIG : ST_INV;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              value_d  = frac_sum;
              weight_d = weight_next;
            end else begin
              err_d = ST_INV;
            end
          end
          default: begin
            phase_d = PH_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      value_q  <= 10'd0;
      weight_q <= W_HUNDREDS;
      err_q    <= ST_OK;
    end else begin
      phase_q  <= phase_d;
      value_q  <= value_d;
      weight_q <= weight_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import qvp_pkg::*;

  localparam int unsigned ItemTarget = 1850;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned TailCycles = 12;

  // Tracks the parser state on accepted characters and holds the results still owed.
  class qvalue_scoreboard;
    qvp_phase_e  phase;
    logic [9:0]  acc;
    logic [6:0]  weight;
    logic [2:0]  ndigits;
    qvp_status_e latched;
    qvp_result_t pending_values[$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase   = PH_START;
      acc     = '0;
      weight  = W_HUNDREDS;
      ndigits = 3'd1;
      latched = ST_OK;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void parse_char(logic [7:0] c);
      logic [9:0] d;
      d = {2'b00, c - CH_ZERO};
      case (phase)
        PH_START: begin
          if (c == CH_SPACE || c == CH_TAB) begin
          end else if (c == CH_ZERO) begin
            acc = '0;
            phase = PH_ZERO;
          end else if (c == CH_ONE) begin
            acc = Q_ONE;
            phase = PH_ONE;
          end else if (c == CH_POINT) begin
            phase = PH_ZPT;
          end else begin
            latched = ST_INV;
          end
        end
        PH_ZERO: begin
          if (c == CH_ZERO) begin
          end else if (c == CH_POINT) begin
            phase = PH_ZPT;
          end else if (c == CH_ONE) begin
            acc = Q_ONE;
            phase = PH_ONE;
          end else begin
            latched = is_digit(c) ? ST_BIG : ST_INV;
          end
        end
        PH_ONE: begin
          if (c == CH_POINT) phase = PH_OPT;
          else latched = is_digit(c) ? ST_BIG : ST_INV;
        end
        PH_ZPT: begin
          if (is_digit(c)) begin
            acc = d * weight;
            weight = weight / W_TENS;
            phase = PH_FRAC;
          end else begin
            latched = ST_INV;
          end
        end
        PH_OPT, PH_OPT0: begin
          if (c == CH_ZERO) phase = PH_OPT0;
          else latched = is_digit(c) ? ST_BIG : ST_INV;
        end
        PH_FRAC: begin
          // The first decimal was taken in PH_ZPT without counting, so the counter
          // runs one behind; digits beyond the third land at weight zero or are dropped.
          if (is_digit(c)) begin
            if (ndigits <= 3'd3) begin
              acc = acc + d * weight;
              weight = weight / W_TENS;
              ndigits = ndigits + 3'd1;
            end
          end else begin
            latched = ST_INV;
          end
        end
        default: phase = PH_START;
      endcase
    endfunction

    function void note_input(logic [7:0] c, logic e);
      qvp_result_t r;
      if (!e) begin
        if (latched == ST_OK) parse_char(c);
        return;
      end
      r.q_thousandths = '0;
      if (latched != ST_OK) r.status = latched;
      else if (phase == PH_START) r.status = ST_EMPTY;
      else if (phase == PH_ZPT || phase == PH_OPT) r.status = ST_DECMISS;
      else begin
        r.status = ST_OK;
        r.q_thousandths = acc;
      end
      pending_values.push_back(r);
      restart();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [9:0] q, logic [2:0] st);
      qvp_result_t want;
      if (pending_values.size() == 0) begin
        report($sformatf("result with nothing owed: q=%0d status=%0d", q, st));
        return;
      end
      want = pending_values.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (q !== want.q_thousandths)
        report($sformatf("q_thousandths %0d, expected %0d", q, want.q_thousandths));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] char_code_i;
  logic       end_mark_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [9:0] q_thousandths_o;
  logic [2:0] status_o;

  qvalue_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          hold_request = 1'b0;
  logic [7:0]  text_q[$];

  sip_qvalue_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_mark_i     (end_mark_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .q_thousandths_o(q_thousandths_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(q_thousandths_o, status_o);
  end

  // The receiver stalls from a repeating random 16-bit pattern that is redrawn periodically,
  // and on request holds off completely for a long stretch.
  initial begin : receiver
    int unsigned cyc;
    int unsigned hold_left;
    logic [15:0] pat;
    cyc = 0;
    hold_left = 0;
    pat = '0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (cyc % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: pat = '0;
          1: pat = 16'($urandom);
          2: pat = 16'($urandom & $urandom);
          default: pat = 16'($urandom | $urandom);
        endcase
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= pat[cyc % 16];
      end
      cyc++;
    end
  end

  task automatic send_item(logic [7:0] c, logic e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    end_mark_i  <= e;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(c, e);
    items_sent++;
  endtask

  task automatic send_text(string s, logic [7:0] end_char);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(end_char, 1'b1);
  endtask

  task automatic send_queue(logic [7:0] end_char);
    foreach (text_q[i]) send_item(text_q[i], 1'b0);
    send_item(end_char, 1'b1);
  endtask

  // Wait with the input idle until every owed result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_POINT;
      3: return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed q strings with random content, some corrupted, some pure noise.
  task automatic build_random();
    int unsigned form;
    text_q.delete();
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
      text_q.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
    form = $urandom_range(0, 19);
    case (form)
      0, 1, 2: repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
      3, 4: text_q.push_back(CH_ONE);
      5, 6, 7: begin
        text_q.push_back(CH_ONE);
        text_q.push_back(CH_POINT);
        repeat ($urandom_range(1, 4)) text_q.push_back(CH_ZERO);
      end
      16: begin
        repeat ($urandom_range(1, 2)) text_q.push_back(CH_ZERO);
        text_q.push_back(CH_ONE);
      end
      17: begin
        case ($urandom_range(0, 2))
          0: text_q.push_back(CH_ONE);
          1: text_q.push_back(CH_ZERO);
          default: ;
        endcase
        text_q.push_back(CH_POINT);
      end
      18: ;
      19: repeat ($urandom_range(1, 8)) text_q.push_back(pick_char());
      default: begin
        repeat ($urandom_range(0, 2)) text_q.push_back(CH_ZERO);
        text_q.push_back(CH_POINT);
        repeat ($urandom_range(1, 6)) text_q.push_back(pick_digit());
      end
    endcase
    if (form != 19 && $urandom_range(0, 6) == 0) begin
      if (text_q.size() != 0) text_q[$urandom_range(0, text_q.size() - 1)] = pick_char();
      else text_q.push_back(pick_char());
    end
  endtask

  initial begin : stimulus
    in_valid_i  = 1'b0;
    char_code_i = '0;
    end_mark_i  = 1'b0;
    rst_ni      = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_text("", 8'hFF);
    send_text(" \t ", 8'h00);
    send_text("000", 8'h30);
    send_text("1", 8'h2E);
    send_text("1.000", 8'h00);
    send_text("1.", 8'h00);
    send_text(".", 8'h00);
    send_text(".5", 8'h00);
    send_text("00.999", 8'h00);
    send_text("0.12345", 8'h00);
    send_text("01", 8'h00);
    send_text("02", 8'h00);
    send_text("12", 8'h00);
    send_text("1.5", 8'h00);
    send_text("1x", 8'h00);
    send_text("0.5x9", 8'h00);
    send_text("2", 8'h00);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);

    // Hold the output long enough that end marks back up into the input.
    drain();
    hold_request = 1'b1;
    repeat (8) send_text("0.5", 8'h00);
    drain();

    while (items_sent < ItemTarget) begin
      build_random();
      send_queue(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 59) == 0) drain();
      if ($urandom_range(0, 149) == 0) hold_request = 1'b1;
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_values.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
